>>> rtl/core/rmse4_pkg.sv
`timescale 1ns / 1ps
package rmse4_pkg;

    localparam int DATA_W = 16;
    localparam int SQ_W   = 32;
    localparam int SUM_W  = 50;
    localparam int ROOT_W = SUM_W / 2;
    localparam int SREM_W = ROOT_W + 3;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_DIV,
        B_SQRT,
        B_NEXT,
        B_OUT
    } back_state_t;

endpackage

>>> rtl/core/rmse4_front.sv
`timescale 1ns / 1ps
module rmse4_front #(
    parameter int LANES     = 4,
    parameter int MAX_PAIRS = 65536,
    parameter int CNT_W     = 17,
    parameter int JOB_W     = 4 * 50 + 17 + 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2*LANES*rmse4_pkg::DATA_W-1:0] in_data,
    input  logic                                 in_last,
    input  logic [1:0]                           q_level,
    output logic                                 push,
    output logic [JOB_W-1:0]                     push_data
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAIRS);
    localparam int DW = rmse4_pkg::DATA_W;
    localparam int SW = rmse4_pkg::SUM_W;

    logic                          s1_valid_reg;
    logic                          s1_last_reg;
    logic [rmse4_pkg::SQ_W-1:0]    s1_sq_reg [LANES];
    logic [SW-1:0]                 sum_reg [LANES];
    logic [CNT_W-1:0]              count_reg;
    logic                          ovf_reg;

    logic [SW-1:0]                 sum_next [LANES];
    logic [CNT_W-1:0]              count_next;
    logic                          ovf_next;
    logic                          full;
    logic [rmse4_pkg::SQ_W-1:0]    sq_in [LANES];
    logic                          accept;

    assign in_ready = (3'(q_level) + 3'(s1_valid_reg && s1_last_reg)) < 3'd2;
    assign accept   = in_valid && in_ready;
    assign full     = count_reg >= MAX_CNT;

    always_comb begin
        logic signed [DW:0] d;
        logic [DW-1:0]      a;
        for (int i = 0; i < LANES; i++) begin
            d = (DW+1)'(signed'(in_data[i*DW +: DW]))
                - (DW+1)'(signed'(in_data[(LANES+i)*DW +: DW]));
            a = d[DW] ? DW'(-d) : d[DW-1:0];
            sq_in[i] = a * a;
        end
    end

    always_comb begin
        logic [SW:0] s;
        for (int i = 0; i < LANES; i++) begin
            s = {1'b0, sum_reg[i]} + (SW+1)'(s1_sq_reg[i]);
            if (full) begin
                sum_next[i] = sum_reg[i];
            end else if (s[SW]) begin
                sum_next[i] = rmse4_pkg::SUM_MAX;
            end else begin
                sum_next[i] = s[SW-1:0];
            end
        end
        count_next = full ? count_reg : count_reg + CNT_W'(1);
        ovf_next   = ovf_reg || full;
    end

    assign push = s1_valid_reg && s1_last_reg;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            push_data[i*SW +: SW] = sum_next[i];
        end
        push_data[LANES*SW +: CNT_W] = count_next;
        push_data[JOB_W-1]           = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                s1_last_reg <= in_last;
                for (int i = 0; i < LANES; i++) begin
                    s1_sq_reg[i] <= sq_in[i];
                end
            end
            if (s1_valid_reg) begin
                if (s1_last_reg) begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    for (int i = 0; i < LANES; i++) begin
                        sum_reg[i] <= '0;
                    end
                end else begin
                    count_reg <= count_next;
                    ovf_reg   <= ovf_next;
                    for (int i = 0; i < LANES; i++) begin
                        sum_reg[i] <= sum_next[i];
                    end
                end
            end
        end
    end

endmodule

>>> rtl/core/rmse4_fifo.sv
`timescale 1ns / 1ps
module rmse4_fifo #(
    parameter int JOB_W = 218
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [JOB_W-1:0] push_data,
    input  logic             pop,
    output logic [JOB_W-1:0] head_data,
    output logic             empty,
    output logic [1:0]       level
);

    logic [JOB_W-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       level_reg;

    assign head_data = mem_reg[rd_ptr_reg];
    assign empty     = level_reg == 2'd0;
    assign level     = level_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            level_reg <= level_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> rtl/core/rmse4_back.sv
`timescale 1ns / 1ps
module rmse4_back #(
    parameter int LANES = 4,
    parameter int CNT_W = 17,
    parameter int JOB_W = 218
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [JOB_W-1:0]                   head_data,
    input  logic                               empty,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [LANES*rmse4_pkg::DATA_W-1:0] out_data,
    output logic                               out_ovf
);

    localparam int SW     = rmse4_pkg::SUM_W;
    localparam int RW     = rmse4_pkg::ROOT_W;
    localparam int MW     = rmse4_pkg::SREM_W;
    localparam int DW     = rmse4_pkg::DATA_W;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

    rmse4_pkg::back_state_t state_reg, state_next;

    logic [JOB_W-1:0]  job_reg;
    logic [LANE_W-1:0] lane_reg;
    logic [5:0]        step_reg;
    logic [SW-1:0]     q_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [RW-1:0]     root_reg;
    logic [MW-1:0]     srem_reg;
    logic [DW-1:0]     res_reg [LANES];
    logic              out_valid_reg;
    logic [LANES*DW-1:0] out_data_reg;
    logic              out_ovf_reg;

    logic [CNT_W-1:0]  divisor;
    logic [CNT_W:0]    dtrial;
    logic              dge;
    logic [MW-1:0]     strial_rem;
    logic [MW-1:0]     strial;
    logic              sge;
    logic              load_out;

    assign divisor    = job_reg[LANES*SW +: CNT_W];
    assign dtrial     = {rem_reg, q_reg[SW-1]};
    assign dge        = dtrial >= {1'b0, divisor};
    assign strial_rem = {srem_reg[MW-3:0], q_reg[SW-1 -: 2]};
    assign strial     = {1'b0, root_reg, 2'b01};
    assign sge        = strial_rem >= strial;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_ovf   = out_ovf_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rmse4_pkg::B_IDLE: if (!empty) state_next = rmse4_pkg::B_LOAD;
            rmse4_pkg::B_LOAD: state_next = rmse4_pkg::B_DIV;
            rmse4_pkg::B_DIV:  if (step_reg == 6'(SW - 1)) state_next = rmse4_pkg::B_SQRT;
            rmse4_pkg::B_SQRT: if (step_reg == 6'(RW - 1)) state_next = rmse4_pkg::B_NEXT;
            rmse4_pkg::B_NEXT: begin
                if (lane_reg == LANE_W'(LANES - 1)) begin
                    state_next = rmse4_pkg::B_OUT;
                end else begin
                    state_next = rmse4_pkg::B_LOAD;
                end
            end
            rmse4_pkg::B_OUT:  if (!out_valid_reg || out_ready) state_next = rmse4_pkg::B_IDLE;
            default:           state_next = rmse4_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            rmse4_pkg::B_IDLE: pop = !empty;
            rmse4_pkg::B_OUT:  load_out = !out_valid_reg || out_ready;
            default: begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rmse4_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg  <= head_data;
            lane_reg <= '0;
        end
        case (state_reg)
            rmse4_pkg::B_LOAD: begin
                q_reg    <= job_reg[lane_reg*SW +: SW];
                rem_reg  <= '0;
                step_reg <= '0;
            end
            rmse4_pkg::B_DIV: begin
                rem_reg  <= dge ? CNT_W'(dtrial - {1'b0, divisor}) : CNT_W'(dtrial);
                q_reg    <= {q_reg[SW-2:0], dge};
                step_reg <= (step_reg == 6'(SW - 1)) ? 6'd0 : step_reg + 6'd1;
                root_reg <= '0;
                srem_reg <= '0;
            end
            rmse4_pkg::B_SQRT: begin
                srem_reg <= sge ? strial_rem - strial : strial_rem;
                root_reg <= {root_reg[RW-2:0], sge};
                q_reg    <= {q_reg[SW-3:0], 2'b00};
                step_reg <= step_reg + 6'd1;
            end
            rmse4_pkg::B_NEXT: begin
                res_reg[lane_reg] <= root_reg[DW-1:0];
                lane_reg          <= lane_reg + LANE_W'(1);
            end
            default: begin
            end
        endcase
        if (load_out) begin
            for (int i = 0; i < LANES; i++) begin
                out_data_reg[i*DW +: DW] <= res_reg[i];
            end
            out_ovf_reg <= job_reg[JOB_W-1];
        end
    end

endmodule

>>> rtl/core/rmse_four_lane_accumulator.sv
`timescale 1ns / 1ps
// Per-lane RMSE of estimate vs. truth. Pairs are accepted one per cycle; each
// lane's squared error goes into a saturating 50-bit sum and pairs are counted
// (saturating at MAX_PAIRS; later pairs are dropped, flagging count_overflow).
// The item with tlast closes the set: its sums and count move through a
// two-entry job queue to a shared back end that, lane by lane, runs a
// restoring divide and a digit square root. Input stalls only when two
// finished sets are already waiting for the back end.
module rmse_four_lane_accumulator #(
    parameter int LANES     = 4,
    parameter int MAX_PAIRS = 65536
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // est_0 .. est_{LANES-1}, truth_0 .. truth_{LANES-1}
    input  logic [2*LANES*rmse4_pkg::DATA_W-1:0] s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // rmse_0 .. rmse_{LANES-1}
    output logic [LANES*rmse4_pkg::DATA_W-1:0]   m_tdata,
    // count_overflow
    output logic                                 m_tuser
);

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int JOB_W = LANES * rmse4_pkg::SUM_W + CNT_W + 1;

    logic             push;
    logic [JOB_W-1:0] push_data;
    logic             pop;
    logic [JOB_W-1:0] head_data;
    logic             empty;
    logic [1:0]       level;

    rmse4_front #(
        .LANES(LANES), .MAX_PAIRS(MAX_PAIRS), .CNT_W(CNT_W), .JOB_W(JOB_W)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(s_tdata), .in_last(s_tlast),
        .q_level(level), .push(push), .push_data(push_data)
    );

    rmse4_fifo #(.JOB_W(JOB_W)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_data(push_data),
        .pop(pop), .head_data(head_data), .empty(empty), .level(level)
    );

    rmse4_back #(.LANES(LANES), .CNT_W(CNT_W), .JOB_W(JOB_W)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .head_data(head_data), .empty(empty), .pop(pop),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(m_tdata), .out_ovf(m_tuser)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int LANES     = 4;
    localparam int MAX_PAIRS = 65536;
    localparam int LIMIT     = 3000000;

    typedef struct packed {
        logic [3:0][15:0] truth;
        logic [3:0][15:0] est;
    } pair_t;

    typedef struct {
        logic [15:0] rmse [LANES];
        logic        ovf;
    } rmse_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [2*LANES*16-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [LANES*16-1:0] m_tdata;
    logic m_tuser;

    rmse_four_lane_accumulator #(.LANES(LANES), .MAX_PAIRS(MAX_PAIRS)) dut (.*);

    always #6 aclk = ~aclk;

    logic [49:0] sums [LANES];
    int unsigned pairs_in_set;
    bit          ovf_seen;
    rmse_t       expected_q [$];
    int          errors = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          overflow_sets = 0;
    longint      cycles = 0;

    function automatic logic [15:0] floor_sqrt(logic [49:0] v);
        logic [63:0] r, b, x;
        r = 0;
        b = 64'd1 << 62;
        x = v;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[15:0];
    endfunction

    function automatic void clear_set();
        foreach (sums[i]) sums[i] = '0;
        pairs_in_set = 0;
        ovf_seen = 1'b0;
    endfunction

    function automatic void accumulate_pair(pair_t p, bit last);
        rmse_t r;
        logic signed [17:0] d;
        logic [63:0] s;
        if (pairs_in_set >= MAX_PAIRS) begin
            ovf_seen = 1'b1;
        end else begin
            for (int i = 0; i < LANES; i++) begin
                d = $signed(p.est[i]) - $signed(p.truth[i]);
                if (d < 0) d = -d;
                s = 64'(sums[i]) + 64'(d) * 64'(d);
                sums[i] = (s > 64'(rmse4_pkg::SUM_MAX)) ? rmse4_pkg::SUM_MAX : s[49:0];
            end
            pairs_in_set++;
        end
        if (last) begin
            for (int i = 0; i < LANES; i++)
                r.rmse[i] = floor_sqrt(sums[i] / pairs_in_set);
            r.ovf = ovf_seen;
            if (ovf_seen) overflow_sets++;
            expected_q = {expected_q, r};
            clear_set();
        end
    endfunction

    task automatic send_pair(pair_t p, bit last);
        s_tdata  <= p;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        accumulate_pair(p, last);
        items_sent++;
        @(negedge aclk);
    endtask

    int gap_left = 0;
    int burst_left = 0;
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_left) @(negedge aclk);
            gap_left = 0;
        end
    endtask

    function automatic pair_t rand_pair(int mode);
        pair_t p;
        for (int i = 0; i < LANES; i++) begin
            case (mode)
                0: begin
                    p.est[i] = $urandom;
                    p.truth[i] = $urandom;
                end
                1: begin
                    p.est[i] = $urandom;
                    p.truth[i] = p.est[i] + 16'($signed($urandom_range(0, 64)) - 32);
                end
                default: begin
                    p.est[i] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    p.truth[i] = ~p.est[i];
                end
            endcase
        end
        return p;
    endfunction

    int stall_phase = 0;
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 1000 < 300)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) < 60);
    end

    always @(posedge aclk) begin
        rmse_t e;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result %h ovf %b", m_tdata, m_tuser);
                errors++;
            end else begin
                e = expected_q.pop_front();
                for (int i = 0; i < LANES; i++)
                    if (m_tdata[16*i +: 16] !== e.rmse[i]) begin
                        $error("rmse_%0d expected %0d actual %0d",
                               i, e.rmse[i], m_tdata[16*i +: 16]);
                        errors++;
                    end
                if (m_tuser !== e.ovf) begin
                    $error("count_overflow expected %b actual %b", e.ovf, m_tuser);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("FAIL rmse_four_lane_accumulator");
            $finish;
        end
    end

    typedef struct {
        logic [15:0] e, t;
        bit          last;
        bit          typed;
        logic [15:0] want;
    } row_t;

    row_t table_rows [] = '{
        '{16'h0000, 16'h0000, 1, 1, 16'd0},
        '{16'h7fff, 16'h8000, 1, 1, 16'd65535},
        '{16'h8000, 16'h7fff, 1, 1, 16'd65535},
        '{16'h0100, 16'h0000, 1, 1, 16'd256},
        '{16'hffff, 16'h0001, 1, 1, 16'd2},
        '{16'h0003, 16'h0000, 0, 0, 16'd0},
        '{16'h0000, 16'h0004, 1, 1, 16'd3},
        '{16'h1234, 16'h1234, 0, 0, 16'd0},
        '{16'h8000, 16'h8000, 1, 1, 16'd0},
        '{16'h5555, 16'haaaa, 1, 0, 16'd0},
        '{16'haaaa, 16'h5555, 1, 0, 16'd0}
    };

    initial begin
        pair_t p;
        int n;
        clear_set();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (table_rows[k]) begin
            for (int i = 0; i < LANES; i++) begin
                p.est[i] = table_rows[k].e;
                p.truth[i] = table_rows[k].t;
            end
            send_pair(p, table_rows[k].last);
            if (table_rows[k].typed)
                for (int i = 0; i < LANES; i++)
                    if (expected_q[$].rmse[i] !== table_rows[k].want) begin
                        $error("row %0d rmse_%0d expected %0d actual %0d",
                               k, i, table_rows[k].want, expected_q[$].rmse[i]);
                        errors++;
                    end
        end
        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        @(negedge aclk);

        while (items_sent < 1450) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            for (int j = 0; j < n; j++) begin
                pace();
                p = rand_pair($urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 4) ? 1 : 2));
                send_pair(p, j == n - 1);
            end
            if ($urandom_range(0, 9) == 0) begin
                s_tvalid <= 1'b0;
                wait (expected_q.size() == 0);
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (400) @(posedge aclk);

        $display("Sent %0d pairs, checked %0d RMSE results, %0d with count overflow.",
                 items_sent, results_seen, overflow_sets);
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS rmse_four_lane_accumulator");
        else
            $display("FAIL rmse_four_lane_accumulator");
        $finish;
    end
endmodule
